// ----- rtl/dfam_pkg.sv -----
// Shared types and constants for the DFA state minimizer.
// Used by dfam_ctrl, dfam_dp and dfa_state_minimizer_top; no dependencies.
package dfam_pkg;

  // Sizes follow from the fixed field widths of the item (6-bit states, 5-bit symbols).
  localparam int MaxStates  = 64;
  localparam int MaxSymbols = 32;
  localparam int StateW     = 6;
  localparam int SymW       = 5;
  localparam int CountW     = 7;
  localparam int EntryW     = StateW + 1;
  localparam int StoreDepth = MaxStates * MaxSymbols;
  localparam int LabelDepth = 2 * MaxStates;
  localparam int InDataW    = 24;
  localparam int OutDataW   = 24;
  localparam int CfgDataW   = 7;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_MIN  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic {
    CFG_STATE_COUNT  = 1'b0,
    CFG_SYMBOL_COUNT = 1'b1
  } cfg_idx_e;

  // Which memory ports the datapath drives this cycle.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_LBL_TS,
    RD_STORE_TS,
    RD_LBL_TGT,
    RD_FIN,
    RD_ITEM,
    RD_REP_TGT
  } rd_sel_e;

  typedef struct packed {
    logic    capture;
    logic    store_we;
    logic    init_begin;
    logic    init_step;
    logic    round_start;
    logic    round_end;
    logic    class_write;
    logic    t_next;
    logic    c_begin;
    logic    c_next;
    logic    fin_write;
    logic    out_load_run;
    logic    out_load_read;
    rd_sel_e rd_sel;
  } dfam_cmd_t;

  typedef struct packed {
    logic t_eq_s;
    logic isrep_t;
    logic lbl_eq;
    logic sym_eq;
    logic c_last;
    logic s_last;
    logic stop;
    logic fin_last;
  } dfam_sts_t;

endpackage

// ----- rtl/dfam_ram.sv -----
// Generic RAM: one write port, two read ports with registered, enabled read data.
// No dependencies.
module dfam_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [Aw-1:0]    raddr_a_i,
  output logic [Width-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [Aw-1:0]    raddr_b_i,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ----- rtl/dfam_dp.sv -----
// Datapath of the DFA minimizer: table, label and representative memories, counters.
// Depends on dfam_pkg and dfam_ram.
module dfam_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dfam_pkg::dfam_cmd_t         cmd_i,
  output dfam_pkg::dfam_sts_t         sts_o,
  input  logic [dfam_pkg::InDataW-1:0] in_data_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [dfam_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [dfam_pkg::OutDataW-1:0] out_data_o,
  output logic                        out_user_o
);
  import dfam_pkg::*;

  localparam int StoreAw = $clog2(StoreDepth);
  localparam int LabelAw = $clog2(LabelDepth);

  logic [StateW-1:0] in_s, in_next;
  logic [SymW-1:0]   in_c;
  logic              in_present, in_acc;

  logic [CountW-1:0] sc_q, n_w;
  logic [5:0]        symc_q, m_w;
  logic [StateW-1:0] s_q, t_q, round_q, item_s_q, first0_q, first1_q;
  logic [SymW-1:0]   c_q, item_c_q;
  logic [CountW-1:0] cnt_q, prev_cnt_q, classes_found_q;
  logic              bank_q, seen0_q, seen1_q;
  logic [MaxStates-1:0] flags_q, isrep_q;

  logic                st_we, st_re_a, st_re_b;
  logic [StoreAw-1:0]  st_ra, st_rb;
  logic [EntryW-1:0]   st_a, st_b;
  logic                lb_we, lb_re_a, lb_re_b;
  logic [LabelAw-1:0]  lb_wa, lb_ra, lb_rb;
  logic [StateW-1:0]   lb_wd, lb_a, lb_b;
  logic                rp_we, rp_re_a, rp_re_b;
  logic [StateW-1:0]   rp_wa, rp_wd, rp_ra, rp_rb, rp_a, rp_b;

  logic              init_f, init_new, dead_a, dead_b;
  logic [StateW-1:0] init_label;

  assign in_s       = in_data_i[5:0];
  assign in_c       = in_data_i[10:6];
  assign in_next    = in_data_i[16:11];
  assign in_present = in_data_i[17];
  assign in_acc     = in_data_i[18];

  // Zero acts as one; large counts saturate.
  assign n_w = (sc_q == '0) ? CountW'(1) : (sc_q > CountW'(MaxStates)) ? CountW'(MaxStates) : sc_q;
  assign m_w = (symc_q == '0) ? 6'd1 : (symc_q > 6'(MaxSymbols)) ? 6'(MaxSymbols) : symc_q;

  assign init_f     = flags_q[s_q];
  assign init_new   = init_f ? !seen1_q : !seen0_q;
  assign init_label = init_new ? s_q : (init_f ? first1_q : first0_q);

  // Memory addressing.
  always_comb begin
    st_re_a = 1'b0; st_re_b = 1'b0; st_ra = '0; st_rb = '0;
    lb_re_a = 1'b0; lb_re_b = 1'b0; lb_ra = '0; lb_rb = '0;
    rp_re_a = 1'b0; rp_re_b = 1'b0; rp_ra = '0; rp_rb = '0;
    unique case (cmd_i.rd_sel)
      RD_LBL_TS: begin
        lb_re_a = 1'b1; lb_ra = {bank_q, t_q};
        lb_re_b = 1'b1; lb_rb = {bank_q, s_q};
      end
      RD_STORE_TS: begin
        st_re_a = 1'b1; st_ra = {t_q, c_q};
        st_re_b = 1'b1; st_rb = {s_q, c_q};
      end
      RD_LBL_TGT: begin
        lb_re_a = 1'b1; lb_ra = {bank_q, st_a[StateW-1:0]};
        lb_re_b = 1'b1; lb_rb = {bank_q, st_b[StateW-1:0]};
      end
      RD_FIN: begin
        lb_re_a = 1'b1; lb_ra = {bank_q, s_q};
      end
      RD_ITEM: begin
        st_re_a = 1'b1; st_ra = {item_s_q, item_c_q};
        rp_re_b = 1'b1; rp_rb = item_s_q;
      end
      RD_REP_TGT: begin
        rp_re_a = 1'b1; rp_ra = st_a[StateW-1:0];
      end
      default: ;
    endcase
  end

  assign st_we = cmd_i.store_we;
  assign lb_we = cmd_i.init_step | cmd_i.class_write;
  assign lb_wa = cmd_i.init_step ? {bank_q, s_q} : {~bank_q, s_q};
  assign lb_wd = cmd_i.init_step ? init_label : t_q;
  assign rp_we = cmd_i.fin_write;
  assign rp_wa = s_q;
  assign rp_wd = ({1'b0, s_q} < n_w) ? lb_a : s_q;

  dfam_ram #(.Width(EntryW), .Depth(StoreDepth)) u_store (
    .clk_i, .we_i(st_we), .waddr_i({in_s, in_c}), .wdata_i({in_present, in_next}),
    .re_a_i(st_re_a), .raddr_a_i(st_ra), .rdata_a_o(st_a),
    .re_b_i(st_re_b), .raddr_b_i(st_rb), .rdata_b_o(st_b)
  );

  // Two label banks: previous round is read, current round is written.
  dfam_ram #(.Width(StateW), .Depth(LabelDepth)) u_label (
    .clk_i, .we_i(lb_we), .waddr_i(lb_wa), .wdata_i(lb_wd),
    .re_a_i(lb_re_a), .raddr_a_i(lb_ra), .rdata_a_o(lb_a),
    .re_b_i(lb_re_b), .raddr_b_i(lb_rb), .rdata_b_o(lb_b)
  );

  dfam_ram #(.Width(StateW), .Depth(MaxStates)) u_rep (
    .clk_i, .we_i(rp_we), .waddr_i(rp_wa), .wdata_i(rp_wd),
    .re_a_i(rp_re_a), .raddr_a_i(rp_ra), .rdata_a_o(rp_a),
    .re_b_i(rp_re_b), .raddr_b_i(rp_rb), .rdata_b_o(rp_b)
  );

  // A missing or out-of-use successor is a class of its own.
  assign dead_a = !st_a[EntryW-1] || ({1'b0, st_a[StateW-1:0]} >= n_w);
  assign dead_b = !st_b[EntryW-1] || ({1'b0, st_b[StateW-1:0]} >= n_w);

  assign sts_o.t_eq_s   = (t_q == s_q);
  assign sts_o.isrep_t  = isrep_q[t_q];
  assign sts_o.lbl_eq   = (lb_a == lb_b);
  assign sts_o.sym_eq   = (dead_a && dead_b) || (!dead_a && !dead_b && lb_a == lb_b);
  assign sts_o.c_last   = ({1'b0, c_q} == m_w - 6'd1);
  assign sts_o.s_last   = ({1'b0, s_q} == n_w - CountW'(1));
  assign sts_o.stop     = (cnt_q == prev_cnt_q) || ({1'b0, round_q} == n_w - CountW'(1));
  assign sts_o.fin_last = (s_q == StateW'(MaxStates - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q            <= CountW'(1);
      symc_q          <= 6'd1;
      flags_q         <= '0;
      isrep_q         <= '0;
      classes_found_q <= '0;
      s_q             <= '0;
      t_q             <= '0;
      c_q             <= '0;
      round_q         <= '0;
      cnt_q           <= '0;
      prev_cnt_q      <= '0;
      bank_q          <= 1'b0;
      seen0_q         <= 1'b0;
      seen1_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_STATE_COUNT:  sc_q   <= cfg_data_i;
          CFG_SYMBOL_COUNT: symc_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (cmd_i.store_we) begin
        flags_q[in_s] <= in_acc;
      end
      if (cmd_i.init_begin) begin
        s_q <= '0; t_q <= '0; round_q <= '0; cnt_q <= '0;
        bank_q <= 1'b0; seen0_q <= 1'b0; seen1_q <= 1'b0;
      end
      if (cmd_i.init_step) begin
        s_q <= s_q + 1'b1;
        if (init_new) begin
          cnt_q <= cnt_q + 1'b1;
          if (init_f) seen1_q <= 1'b1;
          else        seen0_q <= 1'b1;
        end
      end
      if (cmd_i.round_start) begin
        s_q <= '0; t_q <= '0; prev_cnt_q <= cnt_q; cnt_q <= '0;
      end
      if (cmd_i.round_end) begin
        bank_q <= ~bank_q; round_q <= round_q + 1'b1; s_q <= '0; t_q <= '0;
      end
      // Every state below s is rewritten in the current round before it is a candidate.
      if (cmd_i.class_write) begin
        s_q <= s_q + 1'b1;
        t_q <= '0;
        isrep_q[s_q] <= (t_q == s_q);
        if (t_q == s_q) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.t_next)    t_q <= t_q + 1'b1;
      if (cmd_i.c_begin)   c_q <= '0;
      if (cmd_i.c_next)    c_q <= c_q + 1'b1;
      if (cmd_i.fin_write) s_q <= s_q + 1'b1;
      if (cmd_i.out_load_run) classes_found_q <= cnt_q;
    end
  end

  // Payload registers: item capture, first-of-class marks, result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_s_q <= in_s;
      item_c_q <= in_c;
    end
    if (cmd_i.init_step && init_new) begin
      if (init_f) first1_q <= s_q;
      else        first0_q <= s_q;
    end
    if (cmd_i.out_load_run) begin
      out_data_o <= {3'b000, cnt_q, 14'd0};
      out_user_o <= 1'b1;
    end else if (cmd_i.out_load_read) begin
      out_data_o <= {3'b000, classes_found_q, rp_b, flags_q[item_s_q], st_a[EntryW-1], rp_a};
      out_user_o <= 1'b0;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountW'(MaxStates)) else $error("class count above state limit");
  a_t_le_s: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_q <= s_q) else $error("candidate index passed the state under test");
  a_new_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.class_write && (t_q == s_q) |=> isrep_q[$past(s_q)])
    else $error("new class not marked as representative");

endmodule

// ----- rtl/dfam_ctrl.sv -----
// Controller of the DFA minimizer: handshakes and the refinement sequencer.
// Depends on dfam_pkg; drives dfam_dp through command and status structs.
module dfam_ctrl (
  input  logic                rst_ni,
  input  logic                clk_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_op_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dfam_pkg::dfam_cmd_t cmd_o,
  input  dfam_pkg::dfam_sts_t sts_i
);
  import dfam_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_RSTART, ST_TCHK, ST_LCMP, ST_SRD, ST_STGT, ST_SCMP,
    ST_WR, ST_REND, ST_FRD, ST_FWR, ST_DONE, ST_RDA, ST_RDB, ST_RDOUT
  } state_e;

  state_e state_q, state_d;
  logic   in_xfer, out_free, load_out;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;

  always_comb begin
    cmd_o    = '0;
    cmd_o.rd_sel = RD_NONE;
    state_d  = state_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_o.capture = 1'b1;
          case (op_e'(in_op_i))
            OP_LOAD: cmd_o.store_we = 1'b1;
            OP_MIN: begin
              cmd_o.init_begin = 1'b1;
              state_d = ST_INIT;
            end
            OP_READ: state_d = ST_RDA;
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.s_last) state_d = ST_RSTART;
      end
      ST_RSTART: begin
        cmd_o.round_start = 1'b1;
        state_d = ST_TCHK;
      end
      ST_TCHK: begin
        if (sts_i.t_eq_s) begin
          state_d = ST_WR;
        end else if (!sts_i.isrep_t) begin
          cmd_o.t_next = 1'b1;
        end else begin
          cmd_o.rd_sel = RD_LBL_TS;
          state_d = ST_LCMP;
        end
      end
      ST_LCMP: begin
        if (!sts_i.lbl_eq) begin
          cmd_o.t_next = 1'b1;
          state_d = ST_TCHK;
        end else begin
          cmd_o.c_begin = 1'b1;
          state_d = ST_SRD;
        end
      end
      ST_SRD: begin
        cmd_o.rd_sel = RD_STORE_TS;
        state_d = ST_STGT;
      end
      ST_STGT: begin
        cmd_o.rd_sel = RD_LBL_TGT;
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        if (!sts_i.sym_eq) begin
          cmd_o.t_next = 1'b1;
          state_d = ST_TCHK;
        end else if (sts_i.c_last) begin
          state_d = ST_WR;
        end else begin
          cmd_o.c_next = 1'b1;
          state_d = ST_SRD;
        end
      end
      ST_WR: begin
        cmd_o.class_write = 1'b1;
        state_d = sts_i.s_last ? ST_REND : ST_TCHK;
      end
      ST_REND: begin
        cmd_o.round_end = 1'b1;
        state_d = sts_i.stop ? ST_FRD : ST_RSTART;
      end
      ST_FRD: begin
        cmd_o.rd_sel = RD_FIN;
        state_d = ST_FWR;
      end
      ST_FWR: begin
        cmd_o.fin_write = 1'b1;
        state_d = sts_i.fin_last ? ST_DONE : ST_FRD;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load_run = 1'b1;
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_RDA: begin
        cmd_o.rd_sel = RD_ITEM;
        state_d = ST_RDB;
      end
      ST_RDB: begin
        cmd_o.rd_sel = RD_REP_TGT;
        state_d = ST_RDOUT;
      end
      ST_RDOUT: begin
        if (out_free) begin
          cmd_o.out_load_read = 1'b1;
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/dfa_state_minimizer_top.sv -----
// Top level of the DFA state minimizer (Moore partition refinement).
// Depends on dfam_pkg, dfam_ctrl, dfam_dp and dfam_ram.
//
//  - Write state_count (index 0) and symbol_count (index 1) over the cfg channel
//    while the block is idle; cfg_ready_o is always high.
//  - s_axis transfers carry a command in tuser: load entry, minimize or read entry.
//    A load writes one table entry and the source's accepting flag and gives no
//    result; loads stream at one per cycle.
//  - A read passes through the table and source representative read, the target
//    representative read and the result register, which waits while the receiver
//    stalls; the next command is taken once the sequencer is idle again.
//  - A minimize first makes the initial split over the states, then runs rounds that
//    each start and end with a step of their own. Per state a round steps past each
//    lower non-representative, compares labels and each symbol on registered memory
//    reads, and writes the label. Then it writes the representative map for all 64
//    state slots and loads the result: tuser high, carrying the class count.
//  - s_axis_tready is high only while the sequencer is idle; a new command is taken
//    while an earlier result still waits. When the receiver stalls, hold the result;
//    a finished command waits in its last step until the output register frees up.
//  - Reset clears the accepting flags, class count and control state; both counts go
//    to one. Table and labels are not cleared and must be written before they are read.
module dfa_state_minimizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: state_index[5:0], symbol_index[10:6], next_state[16:11],
  // next_present[17], accepting[18], zero pad
  input  logic [dfam_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: mapped_next[5:0], mapped_present[6], state_accepting[7],
  // own_representative[13:8], class_total[20:14], zero pad
  output logic [dfam_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: is_run_done
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [dfam_pkg::CfgDataW-1:0] cfg_data_i
);
  import dfam_pkg::*;

  dfam_cmd_t cmd;
  dfam_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dfam_ctrl u_ctrl (
    .rst_ni,
    .clk_i,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dfam_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i,
    .cfg_data_i,
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser)
  );

endmodule
